FILE: design/erq_pkg.sv
// ----------------------------------------------------------------------------
// erq_pkg
// shared types, codes and widths for the scheduler ready queue
// ----------------------------------------------------------------------------
package erq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_W            = 16;
  localparam int TIME_W          = 32;
  localparam int MODE_W          = 2;

  // in_tdata layout, lowest bit first
  localparam int IN_ID_LSB   = 0;
  localparam int IN_DL_LSB   = IN_ID_LSB + ID_W;
  localparam int IN_PER_LSB  = IN_DL_LSB + TIME_W;
  localparam int IN_CT_LSB   = IN_PER_LSB + TIME_W;
  localparam int IN_KEEP_BIT = IN_CT_LSB + TIME_W;
  localparam int IN_DATA_W   = ((IN_KEEP_BIT + 1 + 7) / 8) * 8;

  // ordering key codes
  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_EDF = 2'd0;
  localparam mode_t MODE_RM  = 2'd1;
  localparam mode_t MODE_SJF = 2'd2;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_SORT   = 2'd1,
    CMD_POP    = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_POP_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] comp_time;
  } entry_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_APPEND,
    DP_SORT_INIT,
    DP_RD_I,
    DP_LD_TEMP,
    DP_RD_J,
    DP_MOVE,
    DP_PUT,
    DP_SCAN_INIT,
    DP_SCAN_RD,
    DP_SCAN_NEXT,
    DP_SHIFT_RD,
    DP_SHIFT_WR,
    DP_SHRINK,
    DP_RD_HEAD,
    DP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    logic    accept;
    dp_op_t  op;
    logic    set_st;
    status_t st;
  } ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic empty;
    logic sort_skip;
    logic j_gt_first;
    logic key_less;
    logic id_match;
    logic scan_end;
    logic nxt_lt_fill;
    logic out_free;
  } stat_t;

endpackage

FILE: design/erq_ctrl.sv
// ----------------------------------------------------------------------------
// erq_ctrl
// command sequencer: sort, scan and shift loops over the entry memory
// ----------------------------------------------------------------------------
module erq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  erq_pkg::stat_t stat,
  output logic           idle,
  output erq_pkg::ctrl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_I,
    S_LD_I,
    S_CHK,
    S_CMP,
    S_PUT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SH_RD,
    S_SH_WR,
    S_HEAD,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  assign idle = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    ctl.accept = 1'b0;
    ctl.op     = erq_pkg::DP_NOP;
    ctl.set_st = 1'b0;
    ctl.st     = erq_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.cmd)
          erq_pkg::CMD_APPEND: begin
            if (stat.full) begin
              ctl.set_st = 1'b1;
              ctl.st     = erq_pkg::ST_FULL;
            end else begin
              ctl.op = erq_pkg::DP_APPEND;
            end
            state_nxt = S_HEAD;
          end
          erq_pkg::CMD_SORT: begin
            if (stat.sort_skip) begin
              state_nxt = S_HEAD;
            end else begin
              ctl.op    = erq_pkg::DP_SORT_INIT;
              state_nxt = S_RD_I;
            end
          end
          erq_pkg::CMD_POP: begin
            if (stat.empty) begin
              ctl.set_st = 1'b1;
              ctl.st     = erq_pkg::ST_POP_EMPTY;
              state_nxt  = S_HEAD;
            end else begin
              ctl.op    = erq_pkg::DP_SCAN_INIT;
              state_nxt = S_SH_RD;
            end
          end
          erq_pkg::CMD_REMOVE: begin
            ctl.op    = erq_pkg::DP_SCAN_INIT;
            state_nxt = S_SCAN_RD;
          end
          default: state_nxt = S_HEAD;
        endcase
      end
      S_RD_I: begin
        ctl.op    = erq_pkg::DP_RD_I;
        state_nxt = S_LD_I;
      end
      S_LD_I: begin
        ctl.op    = erq_pkg::DP_LD_TEMP;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.j_gt_first) begin
          ctl.op    = erq_pkg::DP_RD_J;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_CMP: begin
        if (stat.key_less) begin
          ctl.op    = erq_pkg::DP_MOVE;
          state_nxt = S_CHK;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        ctl.op    = erq_pkg::DP_PUT;
        state_nxt = stat.nxt_lt_fill ? S_RD_I : S_HEAD;
      end
      S_SCAN_RD: begin
        if (stat.scan_end) begin
          ctl.set_st = 1'b1;
          ctl.st     = erq_pkg::ST_NOT_FOUND;
          state_nxt  = S_HEAD;
        end else begin
          ctl.op    = erq_pkg::DP_SCAN_RD;
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat.id_match) begin
          state_nxt = S_SH_RD;
        end else begin
          ctl.op    = erq_pkg::DP_SCAN_NEXT;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SH_RD: begin
        if (stat.nxt_lt_fill) begin
          ctl.op    = erq_pkg::DP_SHIFT_RD;
          state_nxt = S_SH_WR;
        end else begin
          ctl.op    = erq_pkg::DP_SHRINK;
          state_nxt = S_HEAD;
        end
      end
      S_SH_WR: begin
        ctl.op    = erq_pkg::DP_SHIFT_WR;
        state_nxt = S_SH_RD;
      end
      S_HEAD: begin
        ctl.op    = erq_pkg::DP_RD_HEAD;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          ctl.op    = erq_pkg::DP_LOAD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/erq_dp.sv
// ----------------------------------------------------------------------------
// erq_dp
// entry memory, fill count, loop counters, compare logic and result register
// ----------------------------------------------------------------------------
module erq_dp #(
  parameter int QUEUE_DEPTH = erq_pkg::QUEUE_DEPTH_DEF,
  parameter int IDX_W       = $clog2(QUEUE_DEPTH),
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  erq_pkg::ctrl_t           ctl,
  output erq_pkg::stat_t           stat,
  input  logic [1:0]               in_cmd,
  input  erq_pkg::entry_t          in_entry,
  input  logic                     in_keep,
  input  logic                     cfg_wr_en,
  input  erq_pkg::mode_t           cfg_mode,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic                     out_head_valid,
  output logic [erq_pkg::ID_W-1:0] out_head_id,
  output logic [CNT_W-1:0]         out_count,
  output erq_pkg::status_t         out_status
);

  erq_pkg::entry_t  mem_r [QUEUE_DEPTH];
  erq_pkg::entry_t  rd_data_r;
  erq_pkg::entry_t  temp_r;
  erq_pkg::entry_t  req_r;
  erq_pkg::cmd_t    cmd_r;
  logic             keep_r;
  erq_pkg::mode_t   mode_r;
  erq_pkg::status_t status_r;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] i_r;
  logic [CNT_W-1:0] j_r;
  logic             out_valid_r;
  logic             out_head_valid_r;
  logic [erq_pkg::ID_W-1:0] out_head_id_r;
  logic [CNT_W-1:0] out_count_r;
  erq_pkg::status_t out_status_r;

  logic             first;
  logic [CNT_W:0]   i_inc;
  logic [CNT_W:0]   first_inc;
  logic [CNT_W-1:0] j_dec;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] wr_addr;
  erq_pkg::entry_t  wr_data;

  function automatic logic [erq_pkg::TIME_W-1:0] key_of(erq_pkg::entry_t e,
                                                        erq_pkg::mode_t m);
    logic [erq_pkg::TIME_W-1:0] k;
    if (m == erq_pkg::MODE_EDF) k = e.deadline;
    else if (m == erq_pkg::MODE_RM) k = e.period;
    else k = e.comp_time;
    return k;
  endfunction

  // head stays put with keep-head or in shortest-job mode
  assign first     = keep_r | (mode_r == erq_pkg::MODE_SJF);
  assign i_inc     = {1'b0, i_r} + (CNT_W+1)'(1);
  assign first_inc = (CNT_W+1)'(first) + (CNT_W+1)'(1);
  assign j_dec     = j_r - CNT_W'(1);

  always_comb begin
    stat.cmd         = cmd_r;
    stat.full        = (fill_r == CNT_W'(QUEUE_DEPTH));
    stat.empty       = (fill_r == '0);
    stat.sort_skip   = (mode_r > erq_pkg::MODE_SJF) || ({1'b0, fill_r} <= first_inc);
    stat.j_gt_first  = (j_r > CNT_W'(first));
    stat.key_less    = key_of(temp_r, mode_r) < key_of(rd_data_r, mode_r);
    stat.id_match    = (rd_data_r.id == req_r.id);
    stat.scan_end    = (i_r == fill_r);
    stat.nxt_lt_fill = (i_inc < {1'b0, fill_r});
    stat.out_free    = !out_valid_r || out_ready;
  end

  // memory address and data selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    we      = 1'b0;
    wr_addr = j_r[IDX_W-1:0];
    wr_data = rd_data_r;
    unique case (ctl.op)
      erq_pkg::DP_RD_I, erq_pkg::DP_SCAN_RD: begin
        rd_en   = 1'b1;
        rd_addr = i_r[IDX_W-1:0];
      end
      erq_pkg::DP_RD_J: begin
        rd_en   = 1'b1;
        rd_addr = j_dec[IDX_W-1:0];
      end
      erq_pkg::DP_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = i_inc[IDX_W-1:0];
      end
      erq_pkg::DP_RD_HEAD: begin
        rd_en = 1'b1;
      end
      erq_pkg::DP_APPEND: begin
        we      = 1'b1;
        wr_addr = fill_r[IDX_W-1:0];
        wr_data = req_r;
      end
      erq_pkg::DP_MOVE: begin
        we = 1'b1;
      end
      erq_pkg::DP_PUT: begin
        we      = 1'b1;
        wr_data = temp_r;
      end
      erq_pkg::DP_SHIFT_WR: begin
        we      = 1'b1;
        wr_addr = i_r[IDX_W-1:0];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem_r[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem_r[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      req_r  <= in_entry;
      cmd_r  <= erq_pkg::cmd_t'(in_cmd);
      keep_r <= in_keep;
    end
    if (ctl.op == erq_pkg::DP_LD_TEMP) temp_r <= rd_data_r;
    if (ctl.op == erq_pkg::DP_LOAD_OUT) begin
      out_head_valid_r <= (fill_r != '0);
      out_head_id_r    <= (fill_r != '0) ? rd_data_r.id : '0;
      out_count_r      <= fill_r;
      out_status_r     <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      mode_r      <= erq_pkg::MODE_EDF;
      status_r    <= erq_pkg::ST_OK;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_mode;
      if (ctl.accept) status_r <= erq_pkg::ST_OK;
      else if (ctl.set_st) status_r <= ctl.st;
      unique case (ctl.op)
        erq_pkg::DP_APPEND:    fill_r <= fill_r + CNT_W'(1);
        erq_pkg::DP_SHRINK:    fill_r <= fill_r - CNT_W'(1);
        erq_pkg::DP_SORT_INIT: i_r <= first_inc[CNT_W-1:0];
        erq_pkg::DP_LD_TEMP:   j_r <= i_r;
        erq_pkg::DP_MOVE:      j_r <= j_dec;
        erq_pkg::DP_PUT,
        erq_pkg::DP_SCAN_NEXT,
        erq_pkg::DP_SHIFT_WR:  i_r <= i_inc[CNT_W-1:0];
        erq_pkg::DP_SCAN_INIT: i_r <= '0;
        default:               i_r <= i_r;
      endcase
      if (ctl.op == erq_pkg::DP_LOAD_OUT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_head_valid = out_head_valid_r;
  assign out_head_id    = out_head_id_r;
  assign out_count      = out_count_r;
  assign out_status     = out_status_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.op == erq_pkg::DP_APPEND |-> fill_r != CNT_W'(QUEUE_DEPTH))
    else $error("append into a full queue");

  a_shrink_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.op == erq_pkg::DP_SHRINK |-> fill_r != '0)
    else $error("removal from an empty queue");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.op == erq_pkg::DP_LOAD_OUT |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  a_sort_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.op == erq_pkg::DP_PUT |-> i_r < fill_r)
    else $error("sort index past fill count");
`endif

endmodule

FILE: design/edf_rm_sjf_ready_queue_core.sv
// ----------------------------------------------------------------------------
// edf_rm_sjf_ready_queue_core
// ready queue of real-time tasks with append, stable sort, pop and remove
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------
//  in_     | slave     | in_tvalid/tready  | tuser command, tdata task fields
//  out_    | master    | out_tvalid/tready | tdata head, count, status
//  cfg_    | write     | cfg_wr_en         | cfg_wr_data ordering mode
//
//  one item at a time, through an entry memory (one read, one write per
//  cycle): append writes at the end, pop shifts all entries down over the
//  head, remove by id scans for the id and shifts the entries behind it,
//  sort is an insertion sort; the next item is taken as soon as the result
//  sits in the output register, even while it waits for out_tready
//  synchronous active-low reset empties the queue and selects deadline order
//
module edf_rm_sjf_ready_queue_core #(
  parameter int QUEUE_DEPTH = erq_pkg::QUEUE_DEPTH_DEF,
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1),
  parameter int OUT_DATA_W  = ((1 + erq_pkg::ID_W + CNT_W + 2 + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input item
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // task_id, deadline, period, comp_time, keep_head, zero pad
  input  logic [erq_pkg::IN_DATA_W-1:0] in_tdata,
  // command
  input  logic [1:0]                    in_tuser,
  // result item
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // head_valid, head_task_id, entry_count, status, zero pad
  output logic [OUT_DATA_W-1:0]         out_tdata,
  // ordering mode register
  input  logic                          cfg_wr_en,
  input  logic [erq_pkg::MODE_W-1:0]    cfg_wr_data
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  erq_pkg::ctrl_t   ctl;
  erq_pkg::stat_t   stat;
  erq_pkg::entry_t  in_entry;
  logic             idle;
  logic             head_valid;
  logic [erq_pkg::ID_W-1:0] head_id;
  logic [CNT_W-1:0] count;
  erq_pkg::status_t status;

  // unpack the task fields from the input item
  assign in_entry.id        = in_tdata[erq_pkg::IN_ID_LSB  +: erq_pkg::ID_W];
  assign in_entry.deadline  = in_tdata[erq_pkg::IN_DL_LSB  +: erq_pkg::TIME_W];
  assign in_entry.period    = in_tdata[erq_pkg::IN_PER_LSB +: erq_pkg::TIME_W];
  assign in_entry.comp_time = in_tdata[erq_pkg::IN_CT_LSB  +: erq_pkg::TIME_W];

  assign in_tready = idle;

  erq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .stat      (stat),
    .idle      (idle),
    .ctl       (ctl)
  );

  erq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .stat           (stat),
    .in_cmd         (in_tuser),
    .in_entry       (in_entry),
    .in_keep        (in_tdata[erq_pkg::IN_KEEP_BIT]),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_mode       (cfg_wr_data),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .out_head_valid (head_valid),
    .out_head_id    (head_id),
    .out_count      (count),
    .out_status     (status)
  );

  // pack the result, lowest field first, zero filled to whole bytes
  assign out_tdata = OUT_DATA_W'({status, count, head_id, head_valid});

endmodule
